// ===== rtl/core/qdcp_pkg.sv =====
// Shared types, codes and bit-packing helpers for the QR data codeword packer.
package qdcp_pkg;

   // Command codes carried on the request side.
   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_PAD    = 2'd2;

   // Status codes carried on the response side.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_COUNT_WIDE = 2'd1;
   localparam logic [1:0] ST_CAPACITY   = 2'd2;
   localparam logic [1:0] ST_BAD_CHAR   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_VERSION  = 2'd1;
   localparam logic [1:0] CSR_CAPACITY = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [5:0]  VERSION_RESET  = 6'd1;
   localparam logic [11:0] CAPACITY_RESET = 12'd19;

   localparam logic [3:0] MODE_IND_BYTE  = 4'h4;
   localparam logic [3:0] MODE_IND_ALNUM = 4'h2;
   localparam logic [7:0] PAD_FIRST      = 8'hEC;
   localparam logic [7:0] PAD_SECOND     = 8'h11;
   localparam logic [10:0] ALNUM_RADIX   = 11'd45;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   // Response queue: room for the two results of one item on top of two queued entries.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic        mode;
      logic [5:0]  version;
      logic [11:0] capacity;
   } cfg_type;

   typedef struct packed {
      logic [7:0] codeword;
      logic       last;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } rsp_pair_type;

   typedef struct packed {
      logic [23:0] store;
      logic [4:0]  fill;
   } bits_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] idx;
   } alnum_type;

   // Width of the character count field for the mode and the version class.
   function automatic logic [4:0] count_width(input logic mode, input logic [5:0] version);
      logic [4:0] w;
      if (version <= 6'd9) begin
         w = mode ? 5'd9 : 5'd8;
      end else if (version <= 6'd26) begin
         w = mode ? 5'd11 : 5'd16;
      end else begin
         w = mode ? 5'd13 : 5'd16;
      end
      return w;
   endfunction

   // Shifts n bits of v in at the bottom of the pending bit store.
   function automatic bits_type append_bits(input bits_type b, input logic [15:0] v,
                                            input logic [4:0] n);
      bits_type    r;
      logic [23:0] mask;
      logic [5:0]  sum;
      mask    = (24'd1 << n) - 24'd1;
      r.store = (b.store << n) | ({8'd0, v} & mask);
      sum     = {1'b0, b.fill} + {1'b0, n};
      r.fill  = (sum > 6'd24) ? 5'd24 : sum[4:0];
      return r;
   endfunction

   // Index of a character in the 45-symbol alphanumeric set.
   function automatic alnum_type alnum_lookup(input logic [7:0] ch);
      alnum_type r;
      r.ok  = 1'b1;
      r.idx = 6'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r.idx = 6'(ch - 8'h30);
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
         r.idx = 6'(ch - 8'h37);
      end else begin
         case (ch)
            8'h20:   r.idx = 6'd36;
            8'h24:   r.idx = 6'd37;
            8'h25:   r.idx = 6'd38;
            8'h2A:   r.idx = 6'd39;
            8'h2B:   r.idx = 6'd40;
            8'h2D:   r.idx = 6'd41;
            8'h2E:   r.idx = 6'd42;
            8'h2F:   r.idx = 6'd43;
            8'h3A:   r.idx = 6'd44;
            default: r.ok  = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/qr_data_codeword_packer.sv =====
// QR data codeword packer top: input register, CSRs, encoder and response queue.
//
// Packs one single-segment QR message (byte or alphanumeric mode) into data codeword
// bytes. A header beat (tuser command 0) starts a message with its character count,
// character beats (command 1) carry one character each and pad beats (command 2) each
// ask for one more codeword: first the remaining bits with the terminator, then the
// alternating 0xEC/0x11 pad bytes; tlast marks the codeword that fills the capacity.
// Errors come out as a beat with codeword 0 and a nonzero status in rsp_tuser, after
// which character and pad beats are dropped until the next header. A request beat is
// registered and worked once the response queue has room for all its results, which
// enter the response queue at the next edge. One request beat is taken per cycle while
// each yields at most one codeword and the response side keeps up; beats that yield two
// codewords are held back by the single response beat per cycle. The user must write
// the configuration registers only while no message beat is in flight; the block
// itself does not enforce it.
module qr_data_codeword_packer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] char_code, [23:8] char_count
   input  logic [qdcp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] command
   input  logic [qdcp_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] codeword
   output logic [qdcp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // [1:0] status
   output logic [qdcp_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [qdcp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qdcp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import qdcp_pkg::*;

   logic         in_valid_ff;
   logic [1:0]   in_cmd_ff;
   logic [7:0]   in_ch_ff;
   logic [15:0]  in_cnt_ff;
   logic         proc_fire;
   logic         fifo_room;
   cfg_type      cfg;
   rsp_pair_type enc_res;
   rsp_type      rsp_data;

   assign proc_fire  = in_valid_ff && fifo_room;
   assign req_tready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser[1:0];
         in_ch_ff  <= req_tdata[7:0];
         in_cnt_ff <= req_tdata[23:8];
      end
   end

   qdcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qdcp_encoder u_encoder (
      .clock (clock),
      .reset (reset),
      .fire  (proc_fire),
      .cmd   (in_cmd_ff),
      .ch    (in_ch_ff),
      .cnt   (in_cnt_ff),
      .cfg   (cfg),
      .res   (enc_res)
   );

   qdcp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (enc_res),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_data),
      .room      (fifo_room)
   );

   assign rsp_tdata = rsp_data.codeword;
   assign rsp_tlast = rsp_data.last;
   assign rsp_tuser = rsp_data.status;

   // An error beat never carries a codeword or the capacity mark.
   a_error_beat_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == 8'd0 && !rsp_tlast)
      else $error("error beat carries codeword or last");

   // Results are never produced without an item being worked.
   a_no_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      !proc_fire |-> enc_res.count == 2'd0)
      else $error("encoder produced results without an item");

   // After an item produces results, the response side is valid in the next cycle.
   a_result_reaches_output: assert property (@(posedge clock) disable iff (reset)
      proc_fire && enc_res.count != 2'd0 |=> rsp_tvalid)
      else $error("result not presented after processing");

   // A registered item waiting for queue room is kept unchanged.
   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_cmd_ff)
                                    && $stable(in_cnt_ff))
      else $error("waiting request item was lost");

endmodule

// ===== rtl/core/qdcp_csr.sv =====
// Configuration registers of the QR data codeword packer.
module qdcp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [qdcp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qdcp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output qdcp_pkg::cfg_type                cfg
);
   import qdcp_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= 1'b0;
         cfg_ff.version  <= VERSION_RESET;
         cfg_ff.capacity <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:     cfg_ff.mode     <= csr_wdata[0];
            CSR_VERSION:  cfg_ff.version  <= csr_wdata[5:0];
            CSR_CAPACITY: cfg_ff.capacity <= csr_wdata[11:0];
            default:      ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/qdcp_encoder.sv =====
// Bit-stream state and single-pass codeword logic for one item.
module qdcp_encoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [1:0]             cmd,
   input  logic [7:0]             ch,
   input  logic [15:0]            cnt,
   input  qdcp_pkg::cfg_type      cfg,
   output qdcp_pkg::rsp_pair_type res
);
   import qdcp_pkg::*;

   logic [23:0] store_ff;
   logic [4:0]  fill_ff;
   logic [5:0]  held_val_ff, held_val_in;
   logic        held_vld_ff, held_vld_in;
   logic [11:0] sent_ff, sent_in;
   logic        alt_ff, alt_in;
   logic        term_ff, term_in;
   logic        err_ff, err_in;

   bits_type    b;
   logic [4:0]  cb;
   logic        do_emit;
   logic        pad_go;
   logic        stop;
   alnum_type   al;
   logic [10:0] pair_val;
   logic [15:0] total;
   logic [15:0] capbits;
   logic [15:0] spare;
   logic [4:0]  tz;
   logic [2:0]  align;
   logic [7:0]  cw_val;
   rsp_type     slot [2];
   logic [1:0]  nres;

   always_comb begin
      b           = '{store: store_ff, fill: fill_ff};
      held_val_in = held_val_ff;
      held_vld_in = held_vld_ff;
      sent_in     = sent_ff;
      alt_in      = alt_ff;
      term_in     = term_ff;
      err_in      = err_ff;
      cb          = count_width(cfg.mode, cfg.version);
      do_emit     = 1'b0;
      pad_go      = 1'b0;
      stop        = 1'b0;
      al          = alnum_lookup(ch);
      pair_val    = 11'({5'd0, held_val_ff} * ALNUM_RADIX) + {5'd0, al.idx};
      total       = '0;
      capbits     = '0;
      spare       = '0;
      tz          = '0;
      align       = '0;
      cw_val      = '0;
      slot[0]     = '0;
      slot[1]     = '0;
      nres        = 2'd0;

      if (fire) begin
         case (cmd)
            CMD_HEADER: begin
               b           = '0;
               held_val_in = '0;
               held_vld_in = 1'b0;
               sent_in     = '0;
               alt_in      = 1'b0;
               term_in     = 1'b0;
               err_in      = 1'b0;
               if (({1'b0, cnt} >> cb) != 17'd0) begin
                  err_in  = 1'b1;
                  slot[0] = '{codeword: 8'd0, last: 1'b0, status: ST_COUNT_WIDE};
                  nres    = 2'd1;
               end else begin
                  b = append_bits(b, {12'd0, cfg.mode ? MODE_IND_ALNUM : MODE_IND_BYTE},
                                  5'd4);
                  b = append_bits(b, cnt, cb);
                  do_emit = 1'b1;
               end
            end
            CMD_CHAR: begin
               if (!err_ff && !term_ff) begin
                  if (!cfg.mode) begin
                     b       = append_bits(b, {8'd0, ch}, 5'd8);
                     do_emit = 1'b1;
                  end else if (!al.ok) begin
                     err_in  = 1'b1;
                     slot[0] = '{codeword: 8'd0, last: 1'b0, status: ST_BAD_CHAR};
                     nres    = 2'd1;
                  end else if (held_vld_ff) begin
                     b           = append_bits(b, {5'd0, pair_val}, 5'd11);
                     held_vld_in = 1'b0;
                     held_val_in = '0;
                     do_emit     = 1'b1;
                  end else begin
                     held_val_in = al.idx;
                     held_vld_in = 1'b1;
                  end
               end
            end
            CMD_PAD: begin
               if (!err_ff) begin
                  pad_go = 1'b1;
                  if (!term_ff) begin
                     // A lone alphanumeric character goes out in 6 bits.
                     if (held_vld_ff) begin
                        b           = append_bits(b, {10'd0, held_val_ff}, 5'd6);
                        held_vld_in = 1'b0;
                        held_val_in = '0;
                     end
                     total   = {1'b0, sent_ff, 3'b000} + {11'd0, b.fill};
                     capbits = {1'b0, cfg.capacity, 3'b000};
                     if (total > capbits) begin
                        err_in  = 1'b1;
                        pad_go  = 1'b0;
                        slot[0] = '{codeword: 8'd0, last: 1'b0, status: ST_CAPACITY};
                        nres    = 2'd1;
                     end else begin
                        spare   = capbits - total;
                        tz      = (spare > 16'd4) ? 5'd4 : spare[4:0];
                        b       = append_bits(b, 16'd0, tz);
                        align   = 3'd0 - b.fill[2:0];
                        b       = append_bits(b, 16'd0, {2'b00, align});
                        term_in = 1'b1;
                     end
                  end
                  if (pad_go && sent_ff < cfg.capacity) begin
                     if (b.fill >= 5'd8) begin
                        cw_val = 8'(b.store >> (b.fill - 5'd8));
                        b.fill = b.fill - 5'd8;
                     end else begin
                        cw_val = alt_ff ? PAD_SECOND : PAD_FIRST;
                        alt_in = !alt_ff;
                     end
                     sent_in = sent_ff + 12'd1;
                     slot[0] = '{codeword: cw_val, last: sent_in == cfg.capacity,
                                 status: ST_OK};
                     nres    = 2'd1;
                  end
               end
            end
            default: ;
         endcase

         // Whole bytes leave as soon as they are complete, at most two per item.
         if (do_emit) begin
            for (int k = 0; k < 2; k++) begin
               if (!stop && b.fill >= 5'd8) begin
                  if (sent_in >= cfg.capacity) begin
                     err_in  = 1'b1;
                     stop    = 1'b1;
                     slot[k] = '{codeword: 8'd0, last: 1'b0, status: ST_CAPACITY};
                  end else begin
                     cw_val  = 8'(b.store >> (b.fill - 5'd8));
                     b.fill  = b.fill - 5'd8;
                     sent_in = sent_in + 12'd1;
                     slot[k] = '{codeword: cw_val, last: sent_in == cfg.capacity,
                                 status: ST_OK};
                  end
                  nres = 2'(k + 1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff    <= '0;
         fill_ff     <= '0;
         held_val_ff <= '0;
         held_vld_ff <= 1'b0;
         sent_ff     <= '0;
         alt_ff      <= 1'b0;
         term_ff     <= 1'b0;
         err_ff      <= 1'b0;
      end else begin
         store_ff    <= b.store;
         fill_ff     <= b.fill;
         held_val_ff <= held_val_in;
         held_vld_ff <= held_vld_in;
         sent_ff     <= sent_in;
         alt_ff      <= alt_in;
         term_ff     <= term_in;
         err_ff      <= err_in;
      end
   end

   assign res.count = nres;
   assign res.res0  = slot[0];
   assign res.res1  = slot[1];

endmodule

// ===== rtl/core/qdcp_rsp_fifo.sv =====
// Small response queue taking up to two results a cycle and giving one beat a cycle while ready.
module qdcp_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  qdcp_pkg::rsp_pair_type push,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output qdcp_pkg::rsp_type      rsp_data,
   output logic                   room
);
   import qdcp_pkg::*;

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in, wr_next;
   logic [RSP_PTR_W-1:0]   rd_ff, rd_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   always_comb begin
      pop      = (count_ff != '0) && rsp_ready;
      wr_next  = wr_ff + RSP_PTR_W'(1);
      wr_in    = wr_ff + RSP_PTR_W'(push.count);
      rd_in    = rd_ff + RSP_PTR_W'(pop);
      count_in = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ff];
   // Room for both results of the next item, whatever leaves this cycle.
   assign room      = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);

endmodule

// ===== dv/tb_qr_data_codeword_packer.sv =====
// Self-checking testbench for the QR data codeword packer, with a built-in codeword predictor.
module tb_qr_data_codeword_packer;
   import qdcp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 900;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PLAN_LEN = 37;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   qr_data_codeword_packer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: register copies and the message being packed.
   logic [0:0]  cfg_mode;
   logic [5:0]  cfg_version;
   logic [11:0] cfg_capacity;
   logic [23:0] pend_bits;
   int          pend_fill;
   int          held_idx;
   bit          held_ok;
   int          cw_sent;
   bit          pad_toggle;
   bit          term_done;
   bit          msg_error;
   rsp_type     step_out [2];
   int          step_n;
   rsp_type     cw_expected [$];

   string alnum_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

   int mismatches = 0;
   int beats_counted = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   bit rsp_hold_req = 1'b0;

   typedef struct packed {
      logic        csr;
      logic [1:0]  sel;
      logic [7:0]  ch;
      logic [15:0] val;
      logic        typed;
      rsp_type     want;
   } plan_row_type;

   // Rows either write a register (sel is the index, val the data) or send one beat.
   plan_row_type plan [0:PLAN_LEN-1] = '{
      '{1'b0, CMD_HEADER, 8'h00, 16'd255,   1'b1, '{8'h4F, 1'b0, ST_OK}},
      '{1'b0, CMD_HEADER, 8'h00, 16'd256,   1'b1, '{8'h00, 1'b0, ST_COUNT_WIDE}},
      '{1'b0, CMD_CHAR,   "A",   16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_UNUSED, 8'hFF, 16'hFFFF,  1'b0, '0},
      '{1'b1, CSR_CAPACITY, 8'h00, 16'd4,   1'b0, '0},
      '{1'b0, CMD_HEADER, 8'h00, 16'd2,     1'b1, '{8'h40, 1'b0, ST_OK}},
      '{1'b0, CMD_CHAR,   8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_CHAR,   8'hFF, 16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_CHAR,   8'h55, 16'd0,     1'b0, '0},
      '{1'b1, CSR_MODE,     8'h00, 16'd1,    1'b0, '0},
      '{1'b1, CSR_VERSION,  8'h00, 16'd40,   1'b0, '0},
      '{1'b1, CSR_CAPACITY, 8'h00, 16'd2956, 1'b0, '0},
      '{1'b0, CMD_HEADER, 8'h00, 16'd8191,  1'b0, '0},
      '{1'b0, CMD_HEADER, 8'h00, 16'd8192,  1'b1, '{8'h00, 1'b0, ST_COUNT_WIDE}},
      '{1'b0, CMD_HEADER, 8'h00, 16'd3,     1'b0, '0},
      '{1'b0, CMD_CHAR,   "Z",   16'd0,     1'b0, '0},
      '{1'b0, CMD_CHAR,   ":",   16'd0,     1'b0, '0},
      '{1'b0, CMD_CHAR,   "0",   16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_HEADER, 8'h00, 16'd1,     1'b0, '0},
      '{1'b0, CMD_CHAR,   "a",   16'd0,     1'b1, '{8'h00, 1'b0, ST_BAD_CHAR}},
      '{1'b1, CSR_CAPACITY, 8'h00, 16'd1,   1'b0, '0},
      '{1'b1, CSR_VERSION,  8'h00, 16'd0,   1'b0, '0},
      '{1'b0, CMD_HEADER, 8'h00, 16'd511,   1'b0, '0},
      '{1'b0, CMD_CHAR,   "A",   16'd0,     1'b0, '0},
      '{1'b0, CMD_CHAR,   "B",   16'd0,     1'b1, '{8'h00, 1'b0, ST_CAPACITY}},
      '{1'b0, CMD_HEADER, 8'h00, 16'd0,     1'b0, '0},
      '{1'b0, CMD_PAD,    8'h00, 16'd0,     1'b1, '{8'h00, 1'b0, ST_CAPACITY}},
      '{1'b1, CSR_VERSION,  8'h00, 16'd63,  1'b0, '0},
      '{1'b1, CSR_MODE,     8'h00, 16'd0,   1'b0, '0},
      '{1'b0, CMD_HEADER, 8'h00, 16'd65535, 1'b0, '0}
   };

   function automatic void record(input logic [7:0] cw, input bit is_last,
                                  input logic [1:0] st);
      if (step_n < 2) begin
         step_out[step_n] = '{cw, is_last, st};
         step_n++;
      end
   endfunction

   function automatic void abort_message(input logic [1:0] st);
      msg_error = 1'b1;
      record(8'h00, 1'b0, st);
   endfunction

   function automatic void clear_message();
      pend_bits  = '0;
      pend_fill  = 0;
      held_idx   = 0;
      held_ok    = 1'b0;
      cw_sent    = 0;
      pad_toggle = 1'b0;
      term_done  = 1'b0;
      msg_error  = 1'b0;
   endfunction

   function automatic void shift_in(input int unsigned v, input int n);
      if (n == 0 || n > 24) return;
      pend_bits = (pend_bits << n) | 24'(v & ((32'd1 << n) - 32'd1));
      pend_fill = (pend_fill + n > 24) ? 24 : pend_fill + n;
   endfunction

   function automatic logic [7:0] pop_byte();
      logic [7:0] b;
      b = 8'(pend_bits >> (pend_fill - 8));
      pend_fill -= 8;
      return b;
   endfunction

   // A codeword due once the capacity is used up turns into a capacity error.
   function automatic bit put_codeword(input logic [7:0] b);
      if (cw_sent >= cfg_capacity) begin
         abort_message(ST_CAPACITY);
         return 1'b0;
      end
      cw_sent++;
      record(b, cw_sent == cfg_capacity, ST_OK);
      return 1'b1;
   endfunction

   function automatic void drain_bytes();
      while (pend_fill >= 8) begin
         if (!put_codeword(pop_byte())) break;
      end
   endfunction

   function automatic int field_width();
      int cls;
      cls = (cfg_version <= 9) ? 0 : ((cfg_version <= 26) ? 1 : 2);
      if (cfg_mode == 1'b0) return (cls == 0) ? 8 : 16;
      return 9 + 2 * cls;
   endfunction

   function automatic int alnum_pos(input logic [7:0] ch);
      for (int i = 0; i < 45; i++) begin
         if (alnum_chars[i] == ch) return i;
      end
      return -1;
   endfunction

   function automatic void model_beat(input logic [1:0] cmd, input logic [7:0] ch,
                                      input logic [15:0] cnt);
      int w;
      int pos;
      int total;
      int room;
      int t;
      step_n = 0;
      case (cmd)
         CMD_HEADER: begin
            w = field_width();
            clear_message();
            if (cnt >= (32'd1 << w)) begin
               abort_message(ST_COUNT_WIDE);
            end else begin
               shift_in(cfg_mode ? MODE_IND_ALNUM : MODE_IND_BYTE, 4);
               shift_in(cnt, w);
               drain_bytes();
            end
         end
         CMD_CHAR: begin
            // Characters after an error or after the terminator are dropped.
            if (!msg_error && !term_done) begin
               if (cfg_mode == 1'b0) begin
                  shift_in(ch, 8);
                  drain_bytes();
               end else begin
                  pos = alnum_pos(ch);
                  if (pos < 0) begin
                     abort_message(ST_BAD_CHAR);
                  end else if (held_ok) begin
                     shift_in(held_idx * ALNUM_RADIX + pos, 11);
                     held_ok = 1'b0;
                     held_idx = 0;
                     drain_bytes();
                  end else begin
                     held_idx = pos;
                     held_ok = 1'b1;
                  end
               end
            end
         end
         CMD_PAD: begin
            if (msg_error) return;
            if (!term_done) begin
               // A lone alphanumeric character goes out in 6 bits before the terminator.
               if (held_ok) begin
                  shift_in(held_idx, 6);
                  held_ok = 1'b0;
                  held_idx = 0;
               end
               total = cw_sent * 8 + pend_fill;
               room = int'(cfg_capacity) * 8;
               if (total > room) begin
                  abort_message(ST_CAPACITY);
                  return;
               end
               t = (room - total > 4) ? 4 : room - total;
               shift_in(0, t);
               shift_in(0, (8 - (pend_fill % 8)) % 8);
               term_done = 1'b1;
            end
            if (cw_sent < cfg_capacity) begin
               if (pend_fill >= 8) begin
                  void'(put_codeword(pop_byte()));
               end else begin
                  void'(put_codeword(pad_toggle ? PAD_SECOND : PAD_FIRST));
                  pad_toggle = !pad_toggle;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [15:0] cnt, input bit typed, input rsp_type want);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {cnt, ch};
      do @(posedge clock); while (!req_tready);
      model_beat(cmd, ch, cnt);
      beats_counted++;
      if (typed) begin
         cw_expected = {cw_expected, want};
      end else begin
         for (int k = 0; k < step_n; k++) cw_expected = {cw_expected, step_out[k]};
      end
      @(negedge clock);
   endtask

   // Let every expected codeword drain, then give dropped beats time to pass through.
   task automatic quiesce();
      req_tvalid = 1'b0;
      while (cw_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_MODE:     cfg_mode = data[0];
         CSR_VERSION:  cfg_version = data[5:0];
         CSR_CAPACITY: cfg_capacity = data;
         default:      ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic run_message();
      int w;
      int r;
      int n_chars;
      int n_pads;
      int remaining;
      logic [15:0] cnt;
      logic [7:0]  ch;
      w = field_width();
      // Now and then no header is sent and the message left from before carries on.
      if ($urandom_range(0, 9) != 0) begin
         r = $urandom_range(0, 19);
         if (r == 0) cnt = 16'($urandom_range(0, 65535));
         else if (r == 1) cnt = 16'((32'd1 << w) - 1);
         else cnt = 16'($urandom_range(0, 24));
         send_beat(CMD_HEADER, 8'($urandom_range(0, 255)), cnt, 1'b0, '0);
      end else begin
         cnt = 16'($urandom_range(0, 24));
      end
      n_chars = (cnt > 40) ? 40 : cnt;
      if ($urandom_range(0, 4) == 0) n_chars = $urandom_range(0, n_chars + 3);
      repeat (n_chars) begin
         if ($urandom_range(0, 24) == 0) begin
            send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 1'b0, '0);
         end
         if (cfg_mode == 1'b1 && $urandom_range(0, 19) != 0)
            ch = alnum_chars[$urandom_range(0, 44)];
         else ch = 8'($urandom_range(0, 255));
         send_beat(CMD_CHAR, ch, 16'($urandom_range(0, 65535)), 1'b0, '0);
      end
      remaining = int'(cfg_capacity) - cw_sent;
      if (remaining < 0) remaining = 0;
      n_pads = $urandom_range(1, ((remaining > 12) ? 12 : remaining) + 1);
      repeat (n_pads) begin
         send_beat(CMD_PAD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   1'b0, '0);
      end
   endtask

   initial begin : stimulus
      int phase;
      int r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      cfg_mode     = 1'b0;
      cfg_version  = VERSION_RESET;
      cfg_capacity = CAPACITY_RESET;
      clear_message();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].csr) begin
            quiesce();
            write_reg(plan[i].sel, plan[i].val[11:0]);
         end else begin
            send_beat(plan[i].sel, plan[i].ch, plan[i].val, plan[i].typed, plan[i].want);
         end
      end

      phase = 0;
      while (beats_counted < ITEM_TARGET) begin
         quiesce();
         if ($urandom_range(0, 1) != 0) write_reg(CSR_MODE, 12'($urandom_range(0, 1)));
         if ($urandom_range(0, 1) != 0) begin
            r = $urandom_range(0, 15);
            case (r)
               0: write_reg(CSR_VERSION, 12'd0);
               1: write_reg(CSR_VERSION, 12'd63);
               2: write_reg(CSR_VERSION, 12'($urandom_range(41, 62)));
               3: write_reg(CSR_VERSION, 12'd9);
               4: write_reg(CSR_VERSION, 12'd10);
               5: write_reg(CSR_VERSION, 12'd26);
               6: write_reg(CSR_VERSION, 12'd27);
               default: write_reg(CSR_VERSION, 12'($urandom_range(1, 40)));
            endcase
         end
         if ($urandom_range(0, 1) != 0) begin
            r = $urandom_range(0, 19);
            case (r)
               0: write_reg(CSR_CAPACITY, 12'd2956);
               1: write_reg(CSR_CAPACITY, 12'd1);
               2: write_reg(CSR_CAPACITY, 12'd0);
               3: write_reg(CSR_CAPACITY, 12'hFFF);
               default: write_reg(CSR_CAPACITY, 12'($urandom_range(2, 30)));
            endcase
         end
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         // One phase runs with the response side held off so the block backs up.
         if (phase == 2) begin
            req_burst = 1'b1;
            rsp_hold_req = 1'b1;
         end
         repeat ($urandom_range(2, 6)) run_message();
         phase++;
      end

      quiesce();
      if (mismatches == 0) begin
         $display("[qr_data_codeword_packer] OK");
      end else begin
         $display("[qr_data_codeword_packer] ERROR");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall;
      rsp_type want;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (cw_expected.size() == 0) begin
            mismatches++;
            $display("%0t: codeword %h last %b status %0d arrived with none expected",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = cw_expected.pop_front();
            if (rsp_tdata !== want.codeword || rsp_tlast !== want.last ||
                rsp_tuser !== want.status) begin
               mismatches++;
               $display("%0t: expected codeword %h last %b status %0d, actual %h %b %0d",
                        $time, want.codeword, want.last, want.status,
                        rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[qr_data_codeword_packer] ERROR");
      $finish;
   end

endmodule
